// ===== sv/delayed_room_allocator_top_assert.svh =====
// Assertion macros for the delayed room allocator.
// Included by the top level; needs nothing else.
`ifndef DELAYED_ROOM_ALLOCATOR_TOP_ASSERT_SVH
`define DELAYED_ROOM_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define DRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dra_pkg.sv =====
// Shared constants for the delayed room allocator.
// No dependencies.
`default_nettype none

package dra_pkg;

   localparam int CSR_W       = 5;   // num_rooms register width
   localparam int IN_TIME_W   = 32;  // start/end time beat width
   localparam int OUT_TIME_W  = 48;  // actual_start / finish_time width
   localparam int ROOM_OUT_W  = 4;   // room index fields in the result beat

   localparam logic [CSR_W-1:0] NUM_ROOMS_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== sv/dra_room_mem.sv =====
// Room state memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. No package use.
`default_nettype none

module dra_room_mem #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 68,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entry reads as its reset value
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== sv/delayed_room_allocator_top.sv =====
// Delayed room allocator, top level: job sequencer, scan compare, result register.
// Depends on dra_pkg, dra_room_mem and delayed_room_allocator_top_assert.svh.
//
// Takes one job beat (start, end) at a time and books it on the lowest-numbered
// room whose finish time is at or before the start; if none is free, on the room
// that frees first (lowest index on a tie), delayed to that finish time with the
// same duration. Each room's finish time and use count sit in one synchronous
// memory that is read once per active room per job; the active room count is
// csr_wr_data with 0 acting as 1 and above MAX_ROOMS acting as MAX_ROOMS. The
// memory read port reads one entry per cycle during the scan. A new job is taken
// as soon as the previous one is written back, even while its result beat still
// waits on rsp_ready. Memory entries carry valid bits cleared by reset, so the
// block is usable in the first cycle after reset with no clearing pass. Finish
// times saturate at 2^TIME_BITS - 1; the result shows their low 48 bits. Write
// the room count only while no job is in flight.
`default_nettype none

`include "delayed_room_allocator_top_assert.svh"

module delayed_room_allocator_top #(
   parameter int MAX_ROOMS  = 16,
   parameter int TIME_BITS  = 48,
   parameter int COUNT_BITS = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // job beats
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [dra_pkg::IN_TIME_W-1:0]      req_start_time,
   input  wire logic [dra_pkg::IN_TIME_W-1:0]      req_end_time,
   // result beats
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [dra_pkg::ROOM_OUT_W-1:0]     rsp_room,
   output logic      [dra_pkg::OUT_TIME_W-1:0]     rsp_actual_start,
   output logic      [dra_pkg::OUT_TIME_W-1:0]     rsp_finish_time,
   output logic                                    rsp_delayed,
   output logic      [dra_pkg::ROOM_OUT_W-1:0]     rsp_most_used_room,
   // room count register
   input  wire logic                               csr_wr_en,
   input  wire logic [dra_pkg::CSR_W-1:0]          csr_wr_data
);

   localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
   localparam int CNT_W = $clog2(MAX_ROOMS + 1);
   localparam int RN_W  = (CNT_W > dra_pkg::CSR_W) ? CNT_W : dra_pkg::CSR_W;
   localparam int ENT_W = COUNT_BITS + TIME_BITS;
   localparam int RW    = dra_pkg::ROOM_OUT_W;
   localparam int OTW   = dra_pkg::OUT_TIME_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CALC,
      ST_WRITE
   } state_type;

   state_type                  state_ff;
   logic [dra_pkg::CSR_W-1:0]  csr_rooms_ff;
   logic [RN_W-1:0]            n_ff;          // rooms scanned by this job
   logic [RN_W-1:0]            rd_idx_ff;     // next entry to read
   logic                       chk_valid_ff;  // read data returns this cycle
   logic [IDX_W-1:0]           chk_idx_ff;

   logic [dra_pkg::IN_TIME_W-1:0] start_ff;
   logic [dra_pkg::IN_TIME_W-1:0] dur_ff;

   // scan trackers
   logic                       found_ff;
   logic [IDX_W-1:0]           free_idx_ff;
   logic [COUNT_BITS-1:0]      free_uses_ff;
   logic [IDX_W-1:0]           min_idx_ff;
   logic [TIME_BITS-1:0]       min_finish_ff;
   logic [COUNT_BITS-1:0]      min_uses_ff;

   // booking ready for write-back
   logic [IDX_W-1:0]           pick_ff;
   logic [TIME_BITS-1:0]       begin_ff;
   logic [TIME_BITS-1:0]       fin_ff;
   logic [COUNT_BITS-1:0]      uses_ff;
   logic                       late_ff;

   logic [COUNT_BITS-1:0]      best_count_ff;
   logic [IDX_W-1:0]           best_room_ff;

   logic                       rsp_valid_ff;
   logic [RW-1:0]              rsp_room_ff;
   logic [OTW-1:0]             rsp_start_ff;
   logic [OTW-1:0]             rsp_finish_ff;
   logic                       rsp_delayed_ff;
   logic [RW-1:0]              rsp_best_ff;

   logic [RN_W-1:0]               n_eff;
   logic [dra_pkg::IN_TIME_W-1:0] dur_in;
   logic [ENT_W-1:0]              rd_data;
   logic [TIME_BITS-1:0]          ent_finish;
   logic [COUNT_BITS-1:0]         ent_uses;
   logic [TIME_BITS-1:0]          start_ext;
   logic [TIME_BITS-1:0]          sel_begin;
   logic [COUNT_BITS-1:0]         sel_uses;
   logic [TIME_BITS:0]            sum_wide;
   logic [TIME_BITS-1:0]          sel_fin;
   logic [COUNT_BITS-1:0]         uses_inc;
   logic                          out_free;
   logic                          commit;
   logic                          take_best;
   logic [IDX_W-1:0]              new_best_room;
   logic [IDX_W+RW-1:0]           pick_ext;
   logic [IDX_W+RW-1:0]           best_ext;
   logic [TIME_BITS+OTW-1:0]      begin_ext;
   logic [TIME_BITS+OTW-1:0]      fin_ext;
   logic                          scan_last;

   // clamp the room count: zero acts as one, too large acts as MAX_ROOMS
   always_comb begin
      if (csr_rooms_ff == '0) begin
         n_eff = RN_W'(1);
      end else if (RN_W'(csr_rooms_ff) > RN_W'(MAX_ROOMS)) begin
         n_eff = RN_W'(MAX_ROOMS);
      end else begin
         n_eff = RN_W'(csr_rooms_ff);
      end
   end

   // end not after start books zero duration
   assign dur_in = (req_end_time > req_start_time) ? (req_end_time - req_start_time) : '0;

   assign ent_finish = rd_data[TIME_BITS-1:0];
   assign ent_uses   = rd_data[ENT_W-1:TIME_BITS];
   assign start_ext  = TIME_BITS'(start_ff);
   assign scan_last  = (rd_idx_ff + RN_W'(1)) == n_ff;

   // booking: free room keeps the start, else the earliest finisher sets it
   assign sel_begin = found_ff ? start_ext : min_finish_ff;
   assign sel_uses  = found_ff ? free_uses_ff : min_uses_ff;
   assign sum_wide  = {1'b0, sel_begin} + (TIME_BITS + 1)'(dur_ff);
   assign sel_fin   = sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
   assign uses_inc  = (sel_uses == '1) ? sel_uses : (sel_uses + COUNT_BITS'(1));

   // write-back waits until the result register can take the beat
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_WRITE) && out_free;
   assign take_best = (uses_ff > best_count_ff) ||
                      ((uses_ff == best_count_ff) && (pick_ff < best_room_ff));
   assign new_best_room = take_best ? pick_ff : best_room_ff;

   assign pick_ext  = (IDX_W + RW)'(pick_ff);
   assign best_ext  = (IDX_W + RW)'(new_best_room);
   assign begin_ext = (TIME_BITS + OTW)'(begin_ff);
   assign fin_ext   = (TIME_BITS + OTW)'(fin_ff);

   dra_room_mem #(
      .DEPTH  (MAX_ROOMS),
      .DATA_W (ENT_W),
      .ADDR_W (IDX_W)
   ) u_room_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (commit),
      .wr_addr (pick_ff),
      .wr_data ({uses_ff, fin_ff}),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // sequencer and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         csr_rooms_ff  <= dra_pkg::NUM_ROOMS_RESET;
         chk_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         best_count_ff <= '0;
         best_room_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_rooms_ff <= csr_wr_data;
         end
         // a write-back refills the result register as the old beat leaves
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         chk_valid_ff <= (state_ff == ST_SCAN);

         // compare stage: lowest free room and earliest finisher
         if (chk_valid_ff && !found_ff && (ent_finish <= start_ext)) begin
            found_ff <= 1'b1;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (out_free) begin
                  if (take_best) begin
                     best_count_ff <= uses_ff;
                     best_room_ff  <= pick_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         start_ff  <= req_start_time;
         dur_ff    <= dur_in;
         n_ff      <= n_eff;
         rd_idx_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         rd_idx_ff  <= rd_idx_ff + RN_W'(1);
         chk_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
      if (chk_valid_ff) begin
         if (!found_ff && (ent_finish <= start_ext)) begin
            free_idx_ff  <= chk_idx_ff;
            free_uses_ff <= ent_uses;
         end
         if ((chk_idx_ff == '0) || (ent_finish < min_finish_ff)) begin
            min_idx_ff    <= chk_idx_ff;
            min_finish_ff <= ent_finish;
            min_uses_ff   <= ent_uses;
         end
      end
      if (state_ff == ST_CALC) begin
         pick_ff  <= found_ff ? free_idx_ff : min_idx_ff;
         begin_ff <= sel_begin;
         fin_ff   <= sel_fin;
         uses_ff  <= uses_inc;
         late_ff  <= !found_ff;
      end
      if (commit) begin
         rsp_room_ff    <= pick_ext[RW-1:0];
         rsp_start_ff   <= begin_ext[OTW-1:0];
         rsp_finish_ff  <= fin_ext[OTW-1:0];
         rsp_delayed_ff <= late_ff;
         rsp_best_ff    <= best_ext[RW-1:0];
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_room           = rsp_room_ff;
   assign rsp_actual_start   = rsp_start_ff;
   assign rsp_finish_time    = rsp_finish_ff;
   assign rsp_delayed        = rsp_delayed_ff;
   assign rsp_most_used_room = rsp_best_ff;

   // scan never reads past the active rooms
   `DRA_ASSERT_NOW(a_scan_in_range, clock, reset, (state_ff == ST_SCAN), (rd_idx_ff < n_ff), "scan index beyond active rooms")
   // booked room is one of the active rooms
   `DRA_ASSERT_NOW(a_pick_in_range, clock, reset, (state_ff == ST_WRITE), (RN_W'(pick_ff) < n_ff), "booked room beyond active rooms")
   // a delayed job starts strictly after its request, an on-time one exactly on it
   `DRA_ASSERT_NOW(a_delay_start, clock, reset, (state_ff == ST_WRITE), (late_ff ? (begin_ff > start_ext) : (begin_ff == start_ext)), "actual start does not match delayed flag")
   // finish never lands before the actual start
   `DRA_ASSERT_NOW(a_finish_order, clock, reset, (state_ff == ST_WRITE), (fin_ff >= begin_ff), "finish before actual start")
   // each write-back leaves one result beat pending
   `DRA_ASSERT_NEXT(a_commit_beat, clock, reset, commit, rsp_valid_ff, "write-back without result beat")

endmodule

`default_nettype wire

// ===== tb/sv/delayed_room_allocator_top_test.sv =====
// Self-checking testbench for delayed_room_allocator_top.
// Depends on dra_pkg and the block's RTL; holds its own booking predictor and a
// result checker, and drives directed, random and long-job traffic.
`timescale 1ns / 1ps

module delayed_room_allocator_top_test;

   localparam int          MAX_ROOMS  = 16;
   localparam int          TIME_BITS  = 48;
   localparam int          COUNT_BITS = 20;
   localparam logic [63:0] TIME_MAX   = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [19:0] COUNT_MAX  = 20'hF_FFFF;
   // leave margin around csr writes and the end
   localparam int          SETTLE     = 25;
   localparam int          TAIL       = 40;
   localparam int          LIMIT      = 3_000_000;
   localparam int          RAND_JOBS  = 1800;
   localparam int          LONG_JOBS  = 6;

   // expected content of one result beat
   typedef struct packed {
      logic [dra_pkg::ROOM_OUT_W-1:0] room;
      logic [dra_pkg::OUT_TIME_W-1:0] start_at;
      logic [dra_pkg::OUT_TIME_W-1:0] finish;
      logic                           late;
      logic [dra_pkg::ROOM_OUT_W-1:0] busiest;
   } booking_type;

   logic                           clock;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_ready;
   logic [dra_pkg::IN_TIME_W-1:0]  req_start_time = '0;
   logic [dra_pkg::IN_TIME_W-1:0]  req_end_time   = '0;
   logic                           rsp_valid;
   logic                           rsp_ready      = 1'b0;
   logic [dra_pkg::ROOM_OUT_W-1:0] rsp_room;
   logic [dra_pkg::OUT_TIME_W-1:0] rsp_actual_start;
   logic [dra_pkg::OUT_TIME_W-1:0] rsp_finish_time;
   logic                           rsp_delayed;
   logic [dra_pkg::ROOM_OUT_W-1:0] rsp_most_used_room;
   logic                           csr_wr_en      = 1'b0;
   logic [dra_pkg::CSR_W-1:0]      csr_wr_data    = '0;

   // predictor state: a copy of the room table and the room count register
   logic [TIME_BITS-1:0]      finish_at [MAX_ROOMS];
   logic [COUNT_BITS-1:0]     uses_at   [MAX_ROOMS];
   logic [COUNT_BITS-1:0]     top_uses;
   int unsigned               top_room;
   logic [dra_pkg::CSR_W-1:0] rooms_cfg;

   booking_type bookings_due [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          calm        = 1'b0;   // no idling on either side while set

   delayed_room_allocator_top #(
      .MAX_ROOMS  (MAX_ROOMS),
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_time     (req_start_time),
      .req_end_time       (req_end_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_room           (rsp_room),
      .rsp_actual_start   (rsp_actual_start),
      .rsp_finish_time    (rsp_finish_time),
      .rsp_delayed        (rsp_delayed),
      .rsp_most_used_room (rsp_most_used_room),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor: books one job against the copied room table.
   // ---------------------------------------------------------------------------
   function automatic booking_type book_job(input logic [dra_pkg::IN_TIME_W-1:0] s,
                                            input logic [dra_pkg::IN_TIME_W-1:0] e);
      int unsigned n;
      int unsigned pick;
      int unsigned i;
      bit          found;
      logic [63:0] span;
      logic [63:0] t_start;
      logic [63:0] fin;
      booking_type b;
      // room count 0 acts as 1, anything above the table size as the table size
      n = rooms_cfg;
      if (n == 0) n = 1;
      if (n > MAX_ROOMS) n = MAX_ROOMS;
      // end at or before start books a zero-length job
      span  = (e > s) ? {32'd0, e - s} : 64'd0;
      found = 1'b0;
      pick  = 0;
      for (i = 0; i < n; i++) begin
         if (!found && {16'd0, finish_at[i]} <= {32'd0, s}) begin
            pick  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         t_start = {32'd0, s};
      end else begin
         // nothing free: earliest finisher, lowest index on a tie
         pick = 0;
         for (i = 1; i < n; i++) begin
            if (finish_at[i] < finish_at[pick]) pick = i;
         end
         t_start = {16'd0, finish_at[pick]};
      end
      fin = (span > TIME_MAX - t_start) ? TIME_MAX : t_start + span;
      finish_at[pick] = fin[TIME_BITS-1:0];
      if (uses_at[pick] != COUNT_MAX) uses_at[pick] = uses_at[pick] + 1'b1;
      if (uses_at[pick] > top_uses || (uses_at[pick] == top_uses && pick < top_room)) begin
         top_uses = uses_at[pick];
         top_room = pick;
      end
      b.room     = pick[dra_pkg::ROOM_OUT_W-1:0];
      b.start_at = t_start[dra_pkg::OUT_TIME_W-1:0];
      b.finish   = fin[dra_pkg::OUT_TIME_W-1:0];
      b.late     = !found;
      b.busiest  = top_room[dra_pkg::ROOM_OUT_W-1:0];
      return b;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure and the field-by-field check.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 27);
   end

   function automatic void report_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
   endfunction

   always @(posedge clock) begin
      booking_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bookings_due.size() == 0) begin
            error_count++;
            $display("%0t: result beat with nothing expected, room %0d", $time, rsp_room);
         end else begin
            want = bookings_due.pop_front();
            if (rsp_room !== want.room)
               report_field("room", want.room, rsp_room);
            if (rsp_actual_start !== want.start_at)
               report_field("actual_start", want.start_at, rsp_actual_start);
            if (rsp_finish_time !== want.finish)
               report_field("finish_time", want.finish, rsp_finish_time);
            if (rsp_delayed !== want.late)
               report_field("delayed", want.late, rsp_delayed);
            if (rsp_most_used_room !== want.busiest)
               report_field("most_used_room", want.busiest, rsp_most_used_room);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("delayed_room_allocator_top_test: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Job side. Valid stays high across back-to-back beats; it only drops in an
   // idle cycle, so it never gets two assignments in one step.
   // ---------------------------------------------------------------------------
   task automatic send_job(input logic [dra_pkg::IN_TIME_W-1:0] s,
                           input logic [dra_pkg::IN_TIME_W-1:0] e);
      while (!calm && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_time <= s;
      req_end_time   <= e;
      bookings_due = {bookings_due, book_job(s, e)};
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the job side off until every expected beat is back
   task automatic wait_all_booked();
      req_valid <= 1'b0;
      do @(posedge clock); while (bookings_due.size() != 0);
   endtask

   task automatic write_rooms(input logic [dra_pkg::CSR_W-1:0] v);
      wait_all_booked();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rooms_cfg = v;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset count of 16 rooms; zero-length jobs and lowest-free picks.
   task automatic test_lowest_free();
      send_job(32'd0, 32'd0);      // zero length, room 0 free at 0
      send_job(32'd5, 32'd3);      // end before start
      send_job(32'd6, 32'd100);
      send_job(32'd7, 32'd50);     // room 0 busy, goes to room 1
      send_job(32'd8, 32'd60);
   endtask

   // Count 0 behaves as a single room, so jobs queue behind each other.
   task automatic test_single_room_delay();
      write_rooms(5'd0);
      send_job(32'd200, 32'd210);
      send_job(32'd201, 32'd205);  // delayed to 210
      send_job(32'd202, 32'd202);  // delayed, zero length
   endtask

   // All busy with equal finish times: tie goes to the lowest index.
   task automatic test_earliest_tie();
      write_rooms(5'd3);
      send_job(32'd300, 32'd400);
      send_job(32'd301, 32'd400);
      send_job(32'd302, 32'd400);
      send_job(32'd303, 32'd310);
      send_job(32'd304, 32'd305);
   endtask

   // Count above the table size clamps to the table size.
   task automatic test_rooms_clamped();
      write_rooms(5'd31);
      send_job(32'd500, 32'd900);
      send_job(32'd501, 32'd900);
      send_job(32'd502, 32'd900);
   endtask

   // Count lowered with busy rooms beyond it; their state and tally stay put.
   task automatic test_rooms_lowered();
      write_rooms(5'd2);
      send_job(32'd600, 32'd700);
      send_job(32'd601, 32'd650);
   endtask

   // Start times that go backwards or repeat.
   task automatic test_order_broken();
      write_rooms(5'd16);
      send_job(32'd1000, 32'd1500);
      send_job(32'd800, 32'd850);
      send_job(32'd800, 32'd900);
   endtask

   // Mostly sorted job streams with random spacing and load, one room count per phase.
   task automatic test_random_traffic();
      int unsigned               done_jobs;
      int unsigned               phase;
      int unsigned               phase_len;
      int unsigned               n_eff;
      int unsigned               gap_max;
      int unsigned               dur_max;
      int unsigned               gap;
      int unsigned               r;
      int unsigned               i;
      logic [dra_pkg::CSR_W-1:0] cfg;
      logic [63:0]               latest;
      logic [31:0]               cur;
      logic [31:0]               s;
      logic [31:0]               e;
      done_jobs = 0;
      phase     = 0;
      while (done_jobs < RAND_JOBS) begin
         case (phase)
            0: cfg = 5'd16;
            1: cfg = 5'd1;
            2: cfg = 5'd0;
            3: cfg = 5'd31;
            4: cfg = 5'd17;
            5: cfg = 5'd8;
            6: cfg = 5'd2;
            default: cfg = $urandom_range(0, 31);
         endcase
         write_rooms(cfg);
         calm  = (phase == 3);
         n_eff = (cfg == 0) ? 1 : ((cfg > MAX_ROOMS) ? MAX_ROOMS : cfg);
         // start just past the latest finish, or a little before it for early delays
         latest = 0;
         for (i = 0; i < MAX_ROOMS; i++)
            if (finish_at[i] > latest) latest = finish_at[i];
         cur = latest[31:0];
         if ($urandom_range(0, 3) == 0) cur = cur - $urandom_range(0, 200);
         else                           cur = cur + $urandom_range(0, 50);
         gap_max   = $urandom_range(1, 40);
         dur_max   = (gap_max * n_eff * $urandom_range(1, 8)) / 4 + 1;
         phase_len = $urandom_range(80, 200);
         for (i = 0; i < phase_len; i++) begin
            gap = ($urandom_range(0, 99) == 0) ? $urandom_range(1, 1 << 20)
                                               : $urandom_range(1, gap_max);
            r = $urandom_range(0, 99);
            if (r < 5) begin
               // end at or before start
               s   = cur + gap;
               cur = s;
               e   = s - $urandom_range(0, 20);
            end else if (r < 10) begin
               // out of order or repeated start
               s = cur - $urandom_range(0, 300);
               e = s + $urandom_range(1, dur_max);
            end else begin
               s   = cur + gap;
               cur = s;
               e   = s + $urandom_range(1, dur_max);
            end
            send_job(s, e);
            if ($urandom_range(0, 59) == 0) wait_all_booked();
         end
         done_jobs += phase_len;
         phase++;
      end
      calm = 1'b0;
   endtask

   // Full-range start and end values; these leave rooms busy near 2^32.
   task automatic test_time_extremes();
      write_rooms(5'd16);
      send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_job(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_job(32'h0000_0000, 32'hFFFF_FFFF);
      send_job(32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // One room fed maximum-length jobs; the delays push its finish well past 2^32.
   task automatic test_long_jobs();
      write_rooms(5'd1);
      calm = 1'b1;
      repeat (LONG_JOBS) send_job(32'd0, 32'hFFFF_FFFF);
      calm = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < MAX_ROOMS; i++) begin
         finish_at[i] = '0;
         uses_at[i]   = '0;
      end
      top_uses  = '0;
      top_room  = 0;
      rooms_cfg = dra_pkg::NUM_ROOMS_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lowest_free();
      test_single_room_delay();
      test_earliest_tie();
      test_rooms_clamped();
      test_rooms_lowered();
      test_order_broken();
      test_random_traffic();
      test_time_extremes();
      test_long_jobs();

      wait_all_booked();
      repeat (TAIL) @(posedge clock);
      if (error_count == 0) begin
         $display("delayed_room_allocator_top_test: PASS");
      end else begin
         $display("delayed_room_allocator_top_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== delayed_room_allocator_top.f =====
+incdir+sv
sv/dra_pkg.sv
sv/dra_room_mem.sv
sv/delayed_room_allocator_top.sv
tb/sv/delayed_room_allocator_top_test.sv
